/* rtl/core/double_ended_queue_core_defines.svh */
// Assertion macros shared by the deque core.
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DEQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/deq_pkg.sv */
// Types and codes shared by the deque core and its cells.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned ERR_W  = 2;

  // Request codes carried in the op field.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4
  } deq_op_t;

  // Error codes reported with each result.
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } deq_err_t;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic shift_back;   // every cell takes its front neighbor's entry
    logic shift_front;  // every cell takes its back neighbor's entry
    logic append;       // the first free cell loads the request value
  } deq_ctrl_t;

endpackage

/* rtl/core/deq_if.sv */
// Valid/ready channel interfaces for deque requests and results.
`timescale 1ns / 1ps

// Request channel: op code and value.
interface deq_in_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                op;
  logic signed [31:0]        value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

// Result channel: contents summary after each transaction.
interface deq_out_if #(
  parameter int COUNT_W = 5
);
  logic                      valid;
  logic                      ready;
  logic signed [31:0]        front_value;
  logic signed [31:0]        back_value;
  logic [COUNT_W-1:0]        count;
  logic                      empty_res;
  logic                      found;
  logic [1:0]                error;

  modport source (output valid, output front_value, output back_value, output count,
                  output empty_res, output found, output error, input ready);
  modport sink   (input valid, input front_value, input back_value, input count,
                  input empty_res, input found, input error, output ready);
endinterface

/* rtl/core/deq_cell.sv */
// One storage cell of the deque row: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps

module deq_cell #(
  parameter int IDX     = 0,
  parameter int COUNT_W = 5
) (
  input  logic                      clk,
  input  deq_pkg::deq_ctrl_t        ctrl,
  input  logic [COUNT_W-1:0]        count,
  input  logic signed [31:0]        value,
  input  logic signed [31:0]        prev_data,
  input  logic signed [31:0]        next_data,
  output logic signed [31:0]        data,
  output logic                      match,
  output logic signed [31:0]        tail_data
);
  import deq_pkg::*;

  logic held;
  logic is_tail;
  logic is_free_head;

  // Position of this cell relative to the current fill level.
  assign held         = count > COUNT_W'(IDX);
  assign is_tail      = count == COUNT_W'(IDX + 1);
  assign is_free_head = count == COUNT_W'(IDX);

  // Entry update: shift along the row or load the value at the back.
  always_ff @(posedge clk) begin
    priority if (ctrl.shift_back) begin
      data <= prev_data;
    end else if (ctrl.shift_front) begin
      data <= next_data;
    end else if (ctrl.append && is_free_head) begin
      data <= value;
    end else begin
      data <= data;
    end
  end

  // Local compare for searches and masked entry for the back-value select.
  assign match     = held && (data == value);
  assign tail_data = is_tail ? data : '0;

endmodule

/* rtl/core/double_ended_queue_core.sv */
// Top level of the deque: a row of cells with front at cell zero, plus the result register.
//
//   channel   dir   fields
//   req       in    op, value
//   rsp       out   front_value, back_value, count, empty_res, found, error
//
// One request is taken per cycle; each transaction updates the cell row in the cycle it
// is accepted and its result appears on rsp in the next cycle.
// A result stalled on rsp holds the request side off until it is taken; taking it and
// accepting a new request may happen in the same cycle.
// Reset clears the fill count and the result valid; cell contents need no reset.
`timescale 1ns / 1ps

module double_ended_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  deq_in_if.sink    req,
  deq_out_if.source rsp
);
  import deq_pkg::*;
  `include "double_ended_queue_core_defines.svh"

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]           cnt;
  logic [CW-1:0]           cnt_next;
  logic                    rsp_valid;
  logic                    found;
  logic                    found_next;
  deq_err_t                error;
  deq_err_t                error_next;
  deq_ctrl_t               ctrl;
  deq_op_t                 op;
  logic                    accept;
  logic                    is_full;
  logic                    row_empty;
  logic signed [31:0]      cell_data [DEPTH];
  logic signed [31:0]      cell_tail [DEPTH];
  logic [DEPTH-1:0]        cell_match;
  logic signed [31:0]      back_sel;

  // A new request may enter unless an untaken result is waiting.
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign op        = deq_op_t'(req.op);
  assign is_full   = cnt == CW'(DEPTH);
  assign row_empty = cnt == '0;

  // Decode the request into a row command, next count and status.
  always_comb begin
    ctrl       = '0;
    cnt_next   = cnt;
    found_next = 1'b0;
    error_next = ERR_NONE;
    unique case (op)
      OP_PUSH_BACK: begin
        if (is_full) begin
          error_next = ERR_FULL;
        end else begin
          ctrl.append = 1'b1;
          cnt_next    = cnt + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (is_full) begin
          error_next = ERR_FULL;
        end else begin
          ctrl.shift_back = 1'b1;
          cnt_next        = cnt + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (row_empty) begin
          error_next = ERR_EMPTY;
        end else begin
          ctrl.shift_front = 1'b1;
          cnt_next         = cnt - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (row_empty) begin
          error_next = ERR_EMPTY;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      OP_SEARCH: begin
        found_next = |cell_match;
      end
      default: begin
      end
    endcase
    if (!accept) begin
      ctrl = '0;
    end
  end

  // The row of cells; cell zero takes the request value on a front push.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] prev_d;
    logic signed [31:0] next_d;
    if (i == 0) begin : g_first
      assign prev_d = req.value;
    end else begin : g_mid
      assign prev_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_inner
      assign next_d = cell_data[i+1];
    end
    deq_cell #(
      .IDX     (i),
      .COUNT_W (CW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (cnt),
      .value     (req.value),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i]),
      .match     (cell_match[i]),
      .tail_data (cell_tail[i])
    );
  end

  // Only the back cell drives its entry, so an OR picks the back value.
  always_comb begin
    back_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_sel = back_sel | cell_tail[i];
    end
  end

  // Fill count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found <= found_next;
      error <= error_next;
    end
  end

  // Result fields follow the state left by the last accepted request.
  assign rsp.valid       = rsp_valid;
  assign rsp.front_value = row_empty ? '0 : cell_data[0];
  assign rsp.back_value  = back_sel;
  assign rsp.count       = cnt;
  assign rsp.empty_res   = row_empty;
  assign rsp.found       = found;
  assign rsp.error       = error;

  // Checks on the fill count and on the status it reports.
  `DEQ_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, cnt <= CW'(DEPTH),
                   "fill count exceeds depth")
  `DEQ_ASSERT_NEXT(a_push_grows, clk, rst,
                   accept && !is_full && (op == OP_PUSH_BACK || op == OP_PUSH_FRONT),
                   cnt == CW'($past(cnt) + 1'b1), "accepted push did not grow count")
  `DEQ_ASSERT_IMPL(a_full_err, clk, rst, rsp_valid && error == ERR_FULL,
                   cnt == CW'(DEPTH), "full error reported while not full")
  `DEQ_ASSERT_IMPL(a_found_nonempty, clk, rst, rsp_valid && found, !row_empty,
                   "search hit reported on an empty queue")

endmodule

/* test/double_ended_queue_core_tb.sv */
// Self-checking testbench for the deque core: directed table, random traffic, shadow predictor.
`timescale 1ns / 1ps

module double_ended_queue_core_tb;
  import deq_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 800;
  localparam int LONG_HOLD = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  // Contents summary carried by one result transaction.
  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         count;
    logic               empty_res;
    logic               found;
    deq_err_t           error;
  } deque_summary_t;

  // One line of the directed table; a pinned row carries its summary typed in.
  typedef struct {
    logic [2:0]     op;
    logic [31:0]    value;
    int             reps;
    bit             pinned;
    deque_summary_t summary;
  } request_row_t;

  logic clk;
  logic rst;

  deq_in_if req ();
  deq_out_if #(.COUNT_W(5)) rsp ();

  double_ended_queue_core #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Shadow copy of the deque.
  logic signed [31:0] shadow_cells [DEPTH];
  logic [3:0]         shadow_head;
  logic [4:0]         shadow_fill;

  deque_summary_t pending_summaries [$];
  request_row_t   request_table [$];
  int             mismatches;
  bit             cur_pinned;
  deque_summary_t cur_pinned_summary;
  bit             long_hold_req;
  int             send_calm;
  int             sink_calm;

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  // Applies one request to the shadow deque and returns the summary it yields.
  function automatic deque_summary_t apply_request(input logic [2:0] op,
                                                   input logic [31:0] value);
    deque_summary_t s;
    logic [3:0] slot;
    s = '0;
    s.error = ERR_NONE;
    case (op)
      OP_PUSH_BACK: begin
        if (shadow_fill == DEPTH) begin
          s.error = ERR_FULL;
        end else begin
          slot = shadow_head + shadow_fill[3:0];
          shadow_cells[slot] = value;
          shadow_fill = shadow_fill + 5'd1;
        end
      end
      OP_PUSH_FRONT: begin
        if (shadow_fill == DEPTH) begin
          s.error = ERR_FULL;
        end else begin
          shadow_head = shadow_head - 4'd1;
          shadow_cells[shadow_head] = value;
          shadow_fill = shadow_fill + 5'd1;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_fill == 0) begin
          s.error = ERR_EMPTY;
        end else begin
          shadow_head = shadow_head + 4'd1;
          shadow_fill = shadow_fill - 5'd1;
        end
      end
      OP_POP_BACK: begin
        if (shadow_fill == 0) begin
          s.error = ERR_EMPTY;
        end else begin
          shadow_fill = shadow_fill - 5'd1;
        end
      end
      OP_SEARCH: begin
        for (int i = 0; i < DEPTH; i++) begin
          slot = shadow_head + 4'(i);
          if (i < shadow_fill && shadow_cells[slot] == value) begin
            s.found = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (shadow_fill != 0) begin
      slot = shadow_head + shadow_fill[3:0] - 4'd1;
      s.front_value = shadow_cells[shadow_head];
      s.back_value = shadow_cells[slot];
    end
    s.count = shadow_fill;
    s.empty_res = (shadow_fill == 0);
    return s;
  endfunction

  function automatic deque_summary_t summary_of(input logic [31:0] front_value,
                                                input logic [31:0] back_value,
                                                input logic [4:0] count,
                                                input logic empty_res,
                                                input logic found,
                                                input deq_err_t error);
    deque_summary_t s;
    s.front_value = front_value;
    s.back_value = back_value;
    s.count = count;
    s.empty_res = empty_res;
    s.found = found;
    s.error = error;
    return s;
  endfunction

  task automatic add_row(input logic [2:0] op, input logic [31:0] value, input int reps,
                         input bit pinned, input deque_summary_t summary);
    request_row_t row;
    row.op = op;
    row.value = value;
    row.reps = reps;
    row.pinned = pinned;
    row.summary = summary;
    request_table.push_back(row);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Values favor extremes and a small pool so that searches hit duplicates.
  function automatic logic [31:0] pick_value(input bit for_search);
    int r;
    logic [3:0] slot;
    r = $urandom_range(0, 99);
    if (for_search && shadow_fill != 0 && r < 50) begin
      slot = shadow_head + 4'($urandom_range(0, shadow_fill - 1));
      return shadow_cells[slot];
    end
    if (r < 60) begin
      case ($urandom_range(0, 3))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return 32'd0;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (r < 80) return 32'($urandom_range(0, 7));
    return $urandom();
  endfunction

  // Offers one request after a random gap and returns once it is accepted.
  task automatic send_request(input logic [2:0] op, input logic [31:0] value,
                              input bit pinned, input deque_summary_t summary);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      @(negedge clk);
      req.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req.valid <= 1'b1;
    req.op <= op;
    req.value <= value;
    cur_pinned <= pinned;
    cur_pinned_summary <= summary;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int hold;
    rsp.ready = 1'b0;
    sink_calm = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end else begin
        hold = pick_gap(sink_calm);
      end
      if (hold > 0) begin
        rsp.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Checks each result transaction, then predicts from each request transaction.
  always @(posedge clk) begin
    deque_summary_t got;
    deque_summary_t want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        got.front_value = rsp.front_value;
        got.back_value = rsp.back_value;
        got.count = rsp.count;
        got.empty_res = rsp.empty_res;
        got.found = rsp.found;
        got.error = deq_err_t'(rsp.error);
        if (pending_summaries.size() == 0) begin
          report_mismatch("result with nothing pending", got.count, 32'd0);
        end else begin
          want = pending_summaries.pop_front();
          if (got.front_value !== want.front_value)
            report_mismatch("front_value", got.front_value, want.front_value);
          if (got.back_value !== want.back_value)
            report_mismatch("back_value", got.back_value, want.back_value);
          if (got.count !== want.count)
            report_mismatch("count", got.count, want.count);
          if (got.empty_res !== want.empty_res)
            report_mismatch("empty_res", got.empty_res, want.empty_res);
          if (got.found !== want.found)
            report_mismatch("found", got.found, want.found);
          if (got.error !== want.error)
            report_mismatch("error", got.error, want.error);
        end
      end
      if (req.valid && req.ready) begin
        want = apply_request(req.op, req.value);
        if (cur_pinned) want = cur_pinned_summary;
        pending_summaries.push_back(want);
      end
    end
  end

  // Stimulus: reset, directed table, random traffic, then drain.
  initial begin
    int r;
    bit filling;
    logic [2:0] op;
    rst = 1'b1;
    req.valid = 1'b0;
    req.op = OP_PUSH_BACK;
    req.value = '0;
    cur_pinned = 1'b0;
    cur_pinned_summary = '0;
    long_hold_req = 1'b0;
    send_calm = 0;
    mismatches = 0;
    shadow_head = '0;
    shadow_fill = '0;
    for (int i = 0; i < DEPTH; i++) shadow_cells[i] = '0;
    filling = 1'b1;

    // Empty deque: pops fail, search misses, an unused code does nothing.
    add_row(OP_POP_FRONT, 32'd0, 1, 1, summary_of(0, 0, 0, 1, 0, ERR_EMPTY));
    add_row(OP_POP_BACK, VAL_MAX, 1, 1, summary_of(0, 0, 0, 1, 0, ERR_EMPTY));
    add_row(OP_SEARCH, 32'd0, 1, 1, summary_of(0, 0, 0, 1, 0, ERR_NONE));
    add_row(OP_UNUSED_HI, VAL_MIN, 1, 1, summary_of(0, 0, 0, 1, 0, ERR_NONE));
    // Extremes at both ends, then a hit and a miss.
    add_row(OP_PUSH_BACK, VAL_MAX, 1, 1, summary_of(VAL_MAX, VAL_MAX, 1, 0, 0, ERR_NONE));
    add_row(OP_PUSH_FRONT, VAL_MIN, 1, 1, summary_of(VAL_MIN, VAL_MAX, 2, 0, 0, ERR_NONE));
    add_row(OP_SEARCH, VAL_MAX, 1, 1, summary_of(VAL_MIN, VAL_MAX, 2, 0, 1, ERR_NONE));
    add_row(OP_SEARCH, 32'd0, 1, 1, summary_of(VAL_MIN, VAL_MAX, 2, 0, 0, ERR_NONE));
    // Fill to the brim with 100 upward, then pushes on a full deque fail.
    add_row(OP_PUSH_BACK, 32'd100, DEPTH - 2, 0, '0);
    add_row(OP_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1,
            summary_of(VAL_MIN, 32'd113, 16, 0, 0, ERR_FULL));
    add_row(OP_PUSH_BACK, 32'd0, 1, 1, summary_of(VAL_MIN, 32'd113, 16, 0, 0, ERR_FULL));
    add_row(OP_UNUSED_LO, 32'd5, 1, 0, '0);
    add_row(OP_SEARCH, 32'd107, 1, 0, '0);
    add_row(OP_POP_FRONT, 32'd0, 1, 0, '0);
    add_row(OP_POP_BACK, 32'd0, 1, 0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (request_table[i]) begin
      for (int k = 0; k < request_table[i].reps; k++) begin
        send_request(request_table[i].op, request_table[i].value + 32'(k),
                     request_table[i].pinned, request_table[i].summary);
      end
    end
    wait_drained();

    // Random traffic drifting between filling and draining phases.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) filling = $urandom_range(0, 1);
      if (n == 200) begin
        long_hold_req = 1'b1;
        send_calm = 120;
      end
      if (n == 500) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 3) begin
        op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end else if (r < 18) begin
        op = OP_SEARCH;
      end else if (r < (filling ? 70 : 36)) begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      end
      send_request(op, pick_value(op == OP_SEARCH), 1'b0, '0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("double_ended_queue_core verification clean");
    end else begin
      $display("double_ended_queue_core verification failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("double_ended_queue_core verification failed");
    $finish;
  end

endmodule
